// ===== sv/tbrl_pkg.sv =====
// Package: shared types, constants and codes of the token bucket rate limiter.
`timescale 1ns / 1ps

package tbrl_pkg;

    // Field widths
    localparam int CMD_W     = 2;
    localparam int TIME_W    = 64;
    localparam int BYTES_W   = 32;
    localparam int RATE_W    = 24;
    localparam int TOKEN_W   = 32;
    localparam int ELAPSED_W = 40;   // holds the 1000 s clamp
    localparam int PROD_W    = 64;   // elapsed * rate + accumulator
    localparam int FRAC_W    = 30;   // accumulator, always below 1e9
    localparam int QUO_W     = 34;   // whole bytes moved per refill
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 32;

    // Radix-4 divider: two quotient bits per step
    localparam int DIGIT_W   = 2;
    localparam int DIV_STEPS = QUO_W / DIGIT_W;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [ELAPSED_W-1:0] ELAPSED_CAP = 40'd1000000000000;
    localparam logic [31:0] NS_PER_S   = 32'd1000000000;
    localparam logic [31:0] NS_PER_S_2 = 32'd2000000000;
    localparam logic [31:0] NS_PER_S_3 = 32'd3000000000;

    // Commands on the input stream
    localparam logic [CMD_W-1:0] CMD_TAKE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REFILL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RATE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST = 1'b1;

    // Operation chosen by the front end
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_TAKE,
        OP_REFILL,
        OP_RESTART
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_SAT,
        ST_TAKE,
        ST_OUT
    } back_state_t;

    typedef struct packed {
        op_t                op;
        logic [TIME_W-1:0]  now_time;
        logic [BYTES_W-1:0] byte_count;
    } item_t;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUO_W-1:0]  quotient;
        logic [FRAC_W-1:0] remainder;
    } div_res_t;

endpackage

// ===== sv/tbrl_front.sv =====
// Front end: accepts stream transactions and classifies them into operations.
`timescale 1ns / 1ps

module tbrl_front
(
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [tbrl_pkg::CMD_W-1:0]  s_tuser,
    input  logic [95:0]                 s_tdata,
    input  logic [tbrl_pkg::RATE_W-1:0] rate,
    input  logic                        queue_full,
    output logic                        push,
    output tbrl_pkg::item_t             push_item
);

    logic rate_zero;

    assign rate_zero = (rate == '0);
    assign s_tready  = !queue_full;
    assign push      = s_tvalid && !queue_full;

    // A zero rate turns take and refill into no-ops; unused codes do nothing
    always_comb
    begin
        unique case (s_tuser)
            tbrl_pkg::CMD_TAKE:    push_item.op = rate_zero ? tbrl_pkg::OP_HOLD : tbrl_pkg::OP_TAKE;
            tbrl_pkg::CMD_REFILL:  push_item.op = rate_zero ? tbrl_pkg::OP_HOLD : tbrl_pkg::OP_REFILL;
            tbrl_pkg::CMD_RESTART: push_item.op = tbrl_pkg::OP_RESTART;
            default:               push_item.op = tbrl_pkg::OP_HOLD;
        endcase
        push_item.now_time   = s_tdata[tbrl_pkg::TIME_W-1:0];
        push_item.byte_count = s_tdata[tbrl_pkg::TIME_W +: tbrl_pkg::BYTES_W];
    end

endmodule

// ===== sv/tbrl_queue.sv =====
// Short queue of classified items between the front end and the engine.
`timescale 1ns / 1ps

module tbrl_queue
#(
    parameter int DEPTH = tbrl_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tbrl_pkg::item_t push_item,
    input  logic            pop,
    output logic            full,
    output logic            empty,
    output tbrl_pkg::item_t head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tbrl_pkg::item_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/tbrl_div.sv =====
// Radix-4 iterative divider by one second in nanoseconds.
`timescale 1ns / 1ps

module tbrl_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  tbrl_pkg::div_req_t  req,
    output tbrl_pkg::div_res_t  res
);

    localparam int CNT_W = $clog2(tbrl_pkg::DIV_STEPS);

    logic [tbrl_pkg::FRAC_W-1:0] rem_reg;
    logic [tbrl_pkg::QUO_W-1:0]  quo_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [31:0]                 trial;
    logic [31:0]                 diff;
    logic [tbrl_pkg::DIGIT_W-1:0] digit;

    // The dividend's top bits are already below 1e9, so they seed the remainder
    assign trial = {rem_reg, quo_reg[tbrl_pkg::QUO_W-1 -: tbrl_pkg::DIGIT_W]};

    always_comb
    begin
        priority if (trial >= tbrl_pkg::NS_PER_S_3)
        begin
            digit = 2'd3;
            diff  = trial - tbrl_pkg::NS_PER_S_3;
        end
        else if (trial >= tbrl_pkg::NS_PER_S_2)
        begin
            digit = 2'd2;
            diff  = trial - tbrl_pkg::NS_PER_S_2;
        end
        else if (trial >= tbrl_pkg::NS_PER_S)
        begin
            digit = 2'd1;
            diff  = trial - tbrl_pkg::NS_PER_S;
        end
        else
        begin
            digit = 2'd0;
            diff  = trial;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(tbrl_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend[tbrl_pkg::PROD_W-1 -: tbrl_pkg::FRAC_W];
            quo_reg <= req.dividend[tbrl_pkg::QUO_W-1:0];
        end
        else if (busy_reg)
        begin
            rem_reg <= diff[tbrl_pkg::FRAC_W-1:0];
            quo_reg <= {quo_reg[tbrl_pkg::QUO_W-tbrl_pkg::DIGIT_W-1:0], digit};
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

// ===== sv/tbrl_back.sv =====
// Back end: sequencer that refills, grants and holds the bucket state.
`timescale 1ns / 1ps

module tbrl_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tbrl_pkg::RATE_W-1:0]   rate,
    input  logic [tbrl_pkg::TOKEN_W-1:0]  burst,
    input  logic                          queue_empty,
    input  tbrl_pkg::item_t               head_item,
    output logic                          pop,
    output tbrl_pkg::div_req_t            div_req,
    input  tbrl_pkg::div_res_t            div_res,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic                          m_granted,
    output logic [tbrl_pkg::TOKEN_W-1:0]  m_tokens
);

    localparam int SUM_W = tbrl_pkg::QUO_W + 1;

    tbrl_pkg::back_state_t state_reg, state_next;
    tbrl_pkg::item_t       item_reg, item_next;

    logic [tbrl_pkg::TOKEN_W-1:0]   token_reg, token_next;
    logic [tbrl_pkg::TIME_W-1:0]    last_time_reg, last_time_next;
    logic [tbrl_pkg::FRAC_W-1:0]    acc_reg, acc_next;
    logic [tbrl_pkg::ELAPSED_W-1:0] elapsed_reg, elapsed_next;
    logic [tbrl_pkg::PROD_W-1:0]    prod_reg, prod_next;
    logic                           grant_reg, grant_next;
    logic                           m_valid_reg, m_valid_next;
    logic                           m_granted_reg, m_granted_next;
    logic [tbrl_pkg::TOKEN_W-1:0]   m_tokens_reg, m_tokens_next;

    logic [tbrl_pkg::TIME_W:0]      delta;
    logic [SUM_W-1:0]               sum;

    assign delta = {1'b0, item_reg.now_time} - {1'b0, last_time_reg};
    assign sum   = SUM_W'(token_reg) + SUM_W'(div_res.quotient);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        token_next     = token_reg;
        last_time_next = last_time_reg;
        acc_next       = acc_reg;
        elapsed_next   = elapsed_reg;
        prod_next      = prod_reg;
        grant_next     = grant_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_granted_next = m_granted_reg;
        m_tokens_next  = m_tokens_reg;
        pop            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg + tbrl_pkg::PROD_W'(acc_reg);

        unique case (state_reg)
            tbrl_pkg::ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    item_next  = head_item;
                    state_next = tbrl_pkg::ST_EXEC;
                end
            end
            tbrl_pkg::ST_EXEC:
            begin
                grant_next = 1'b1;
                unique case (item_reg.op)
                    tbrl_pkg::OP_HOLD:
                    begin
                        state_next = tbrl_pkg::ST_OUT;
                    end
                    tbrl_pkg::OP_RESTART:
                    begin
                        token_next     = burst;
                        last_time_next = item_reg.now_time;
                        acc_next       = '0;
                        state_next     = tbrl_pkg::ST_OUT;
                    end
                    default:
                    begin
                        // Clock going backwards counts as no time; long gaps clamp
                        if (delta[tbrl_pkg::TIME_W])
                        begin
                            elapsed_next = '0;
                        end
                        else if (delta[tbrl_pkg::TIME_W-1:0] >
                                 tbrl_pkg::TIME_W'(tbrl_pkg::ELAPSED_CAP))
                        begin
                            elapsed_next = tbrl_pkg::ELAPSED_CAP;
                        end
                        else
                        begin
                            elapsed_next = delta[tbrl_pkg::ELAPSED_W-1:0];
                        end
                        last_time_next = item_reg.now_time;
                        state_next     = tbrl_pkg::ST_MUL;
                    end
                endcase
            end
            tbrl_pkg::ST_MUL:
            begin
                prod_next  = tbrl_pkg::PROD_W'(elapsed_reg) * tbrl_pkg::PROD_W'(rate);
                state_next = tbrl_pkg::ST_ADD;
            end
            tbrl_pkg::ST_ADD:
            begin
                div_req.start = 1'b1;
                state_next    = tbrl_pkg::ST_DIV;
            end
            tbrl_pkg::ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = tbrl_pkg::ST_SAT;
                end
            end
            tbrl_pkg::ST_SAT:
            begin
                // A full bucket drops its fractional credit
                if (sum >= SUM_W'(burst))
                begin
                    token_next = burst;
                    acc_next   = '0;
                end
                else
                begin
                    token_next = sum[tbrl_pkg::TOKEN_W-1:0];
                    acc_next   = div_res.remainder;
                end
                state_next = (item_reg.op == tbrl_pkg::OP_TAKE) ? tbrl_pkg::ST_TAKE
                                                                : tbrl_pkg::ST_OUT;
            end
            tbrl_pkg::ST_TAKE:
            begin
                if (item_reg.byte_count > token_reg)
                begin
                    grant_next = 1'b0;
                end
                else
                begin
                    token_next = token_reg - item_reg.byte_count;
                end
                state_next = tbrl_pkg::ST_OUT;
            end
            tbrl_pkg::ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next   = 1'b1;
                    m_granted_next = grant_reg;
                    m_tokens_next  = token_reg;
                    state_next     = tbrl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tbrl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tbrl_pkg::ST_IDLE;
            token_reg     <= '0;
            last_time_reg <= '0;
            acc_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            token_reg     <= token_next;
            last_time_reg <= last_time_next;
            acc_reg       <= acc_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        elapsed_reg   <= elapsed_next;
        prod_reg      <= prod_next;
        grant_reg     <= grant_next;
        m_granted_reg <= m_granted_next;
        m_tokens_reg  <= m_tokens_next;
    end

    assign m_tvalid  = m_valid_reg;
    assign m_granted = m_granted_reg;
    assign m_tokens  = m_tokens_reg;

endmodule

// ===== sv/token_bucket_rate_limiter.sv =====
// Top level: token bucket rate limiter with stream ports and a config write port.
// Restart, zero-rate and unused commands pass through the engine's EXEC and OUT states;
// refill also multiplies, runs the 17-step radix-4 divide by 1e9 and saturates, and take
// then deducts too. The single engine works on one item at a time while the queue takes
// up to two more.
// Reset (rst_n, asynchronous, active low) empties the queue and output register,
// sets rate and burst to zero, tokens to zero, last time and accumulator to zero.
`timescale 1ns / 1ps

module token_bucket_rate_limiter
#(
    parameter int QUEUE_DEPTH = tbrl_pkg::QUEUE_DEPTH
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [95:0]                     s_tdata,   // [63:0] now_time, [95:64] byte_count
    input  logic [tbrl_pkg::CMD_W-1:0]      s_tuser,   // [1:0] command
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [39:0]                     m_tdata,   // [0] granted, [32:1] tokens_left, zero pad
    // Configuration writes
    input  logic                            cfg_we,
    input  logic [tbrl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tbrl_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [tbrl_pkg::RATE_W-1:0]  rate_reg;
    logic [tbrl_pkg::TOKEN_W-1:0] burst_reg;

    logic                         push;
    tbrl_pkg::item_t              push_item;
    logic                         pop;
    logic                         queue_full;
    logic                         queue_empty;
    tbrl_pkg::item_t              head_item;
    tbrl_pkg::div_req_t           div_req;
    tbrl_pkg::div_res_t           div_res;
    logic                         m_granted;
    logic [tbrl_pkg::TOKEN_W-1:0] m_tokens;

    // Config registers; the user must write them only while the block is idle (not enforced here)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= '0;
            burst_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tbrl_pkg::REG_RATE:  rate_reg  <= cfg_data[tbrl_pkg::RATE_W-1:0];
                tbrl_pkg::REG_BURST: burst_reg <= cfg_data[tbrl_pkg::TOKEN_W-1:0];
                default:             rate_reg  <= rate_reg;
            endcase
        end
    end

    // Classify each transaction as it arrives; zero rate folds take/refill to hold
    tbrl_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .rate       (rate_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // Decouple intake from the multi-cycle engine
    tbrl_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .empty     (queue_empty),
        .head_item (head_item)
    );

    // Engine: elapsed time, multiply by rate, divide, saturate, deduct
    tbrl_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rate        (rate_reg),
        .burst       (burst_reg),
        .queue_empty (queue_empty),
        .head_item   (head_item),
        .pop         (pop),
        .div_req     (div_req),
        .div_res     (div_res),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_granted   (m_granted),
        .m_tokens    (m_tokens)
    );

    // Convert byte-nanoseconds to whole bytes plus remainder
    tbrl_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .res   (div_res)
    );

    // Pack the result transaction, granted in the lowest bit
    assign m_tdata = {7'b0, m_tokens, m_granted};

endmodule

// ===== sv/tbrl_checker.sv =====
// Checker: port-level assertions for the rate limiter, bound to the top level.
`timescale 1ns / 1ps

module tbrl_checker
#(
    parameter int DEPTH = tbrl_pkg::QUEUE_DEPTH
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    logic [7:0] pending_reg;
    logic       s_fire;
    logic       m_fire;

    assign s_fire = s_tvalid && s_tready;
    assign m_fire = m_tvalid && m_tready;

    // Count transactions accepted whose results are not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + {7'b0, s_fire} - {7'b0, m_fire};
        end
    end

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rst_n && !$past(rst_n)) |-> !m_tvalid)
        else $error("result shown right after reset");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (pending_reg != 8'd0))
        else $error("result without an accepted transaction");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 8'(DEPTH + 2))
        else $error("more transactions in flight than storage allows");

endmodule

bind token_bucket_rate_limiter tbrl_checker
#(
    .DEPTH (QUEUE_DEPTH)
)
u_tbrl_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
